// ===== rtl/core/bhpq_pkg.sv =====
// shared types and codes for the binary heap priority queue
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int DATA_IO_W  = 32;
  localparam int ENTRIES_W  = 7;

  typedef logic       opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_INSERT  = 1'b0;
  localparam opcode_t OP_EXTRACT = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef struct packed {
    opcode_t                opcode;
    logic [DATA_IO_W-1:0]   data_in;
  } cmd_t;

  typedef struct packed {
    logic [DATA_IO_W-1:0]   data_out;
    logic                   is_empty;
    logic [ENTRIES_W-1:0]   entries;
    status_t                status;
  } rsp_t;

endpackage

// ===== rtl/core/binary_heap_priority_queue_unit.sv =====
// binary heap priority queue: sequencer, heap memory and shared compare unit
`timescale 1ns / 1ps

// channel  | signals             | direction | transfer when
// ---------+---------------------+-----------+------------------------------
// command  | start, cmd, busy    | in        | rising edge with start & !busy
// result   | done, rsp           | out       | every cycle done is high
// config   | cfg_we, cfg_wdata   | in        | rising edge with cfg_we
//
// an insert reads each parent (INS_RD) and compares it (INS_EV) until the
// value settles or reaches the root; an extract reads root and last entry
// (EXT_RD0, EXT_LD), then per level descended reads the children (EXT_RD)
// and compares (EXT_EV), ending at a leaf or where no child ranks ahead;
// every compare waits on the registered read of the heap memory
// a refused insert (full) or extract (empty) reports in the next cycle
// rst is synchronous: count and order clear at once, heap contents stay as-is
// done is a one-cycle strobe; the receiver cannot stall the result
module binary_heap_priority_queue_unit #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bhpq_pkg::cmd_t cmd,
  output logic          busy,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  output logic          done,
  output bhpq_pkg::rsp_t rsp
);

  import bhpq_pkg::*;

  // slot numbers run 1..CAPACITY, memory addresses 0..CAPACITY-1
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [2:0] {
    IDLE,
    INS_RD,
    INS_EV,
    EXT_RD0,
    EXT_LD,
    EXT_RD,
    EXT_EV
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;      // live entries; during extract it is the new size
  logic                  mode;       // 0 largest first, 1 smallest first
  logic [CW-1:0]         pos;        // current slot of the moving entry
  logic [DATA_WIDTH-1:0] val;        // value being inserted
  logic [DATA_WIDTH-1:0] top;        // root taken by an extract
  logic [DATA_WIDTH-1:0] moving;     // last entry sifting down

  // heap memory: one write port, two registered read ports
  logic [DATA_WIDTH-1:0] heap_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] qa, qb;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa, ra, rb;
  logic [DATA_WIDTH-1:0] mem_wd;

  // compare unit
  logic [CW:0]           left;
  logic                  left_in;    // left child slot is live
  logic                  has_right;
  logic                  right_wins;
  logic [DATA_WIDTH-1:0] child;
  logic [CW-1:0]         pick_slot;
  logic                  child_up;
  logic                  ins_up;

  // true when a is strictly ahead of b under the current order
  function automatic logic ranks(input logic [DATA_WIDTH-1:0] a,
                                 input logic [DATA_WIDTH-1:0] b,
                                 input logic m);
    ranks = m ? (a < b) : (a > b);
  endfunction

  assign busy = (state != IDLE);

  always_comb begin
    left       = {pos, 1'b0};
    left_in    = (left <= {1'b0, count});
    has_right  = (left < {1'b0, count});
    right_wins = has_right && ranks(qb, qa, mode);
    child      = right_wins ? qb : qa;
    pick_slot  = right_wins ? CW'(left + 1'b1) : CW'(left);
    child_up   = ranks(child, moving, mode);
    ins_up     = ranks(val, qa, mode);

    mem_we = 1'b0;
    mem_wa = AW'(pos - ONE_C);
    mem_wd = val;
    ra     = '0;
    rb     = '0;
    case (state)
      INS_RD: begin
        if (pos == ONE_C) begin
          mem_we = 1'b1;
        end else begin
          ra = AW'((pos >> 1) - ONE_C);
        end
      end
      INS_EV: begin
        // parent slides down, or the new value settles here
        mem_we = 1'b1;
        mem_wd = ins_up ? qa : val;
      end
      EXT_RD0: begin
        ra = '0;
        rb = AW'(count);   // old last slot, address count after decrement
      end
      EXT_RD: begin
        if (!left_in) begin
          mem_we = (count != '0);
          mem_wd = moving;
        end else begin
          ra = AW'(left - 1'b1);
          rb = AW'(left);
        end
      end
      EXT_EV: begin
        mem_we = 1'b1;
        mem_wd = child_up ? child : moving;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    qa <= heap_mem[ra];
    qb <= heap_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      mode  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      case (state)
        IDLE: begin
          if (start) begin
            if (cmd.opcode == OP_INSERT) begin
              if (count >= CAP_C) begin
                done         <= 1'b1;
                rsp.data_out <= '0;
                rsp.is_empty <= (count == '0);
                rsp.entries  <= ENTRIES_W'(count);
                rsp.status   <= ST_FULL;
              end else begin
                val   <= DATA_WIDTH'(cmd.data_in);
                pos   <= count + ONE_C;
                count <= count + ONE_C;
                state <= INS_RD;
              end
            end else begin
              if (count == '0) begin
                done         <= 1'b1;
                rsp.data_out <= '0;
                rsp.is_empty <= 1'b1;
                rsp.entries  <= '0;
                rsp.status   <= ST_EMPTY;
              end else begin
                count <= count - ONE_C;
                state <= EXT_RD0;
              end
            end
          end
        end
        INS_RD: begin
          if (pos == ONE_C) begin
            done         <= 1'b1;
            rsp.data_out <= '0;
            rsp.is_empty <= (count == '0);
            rsp.entries  <= ENTRIES_W'(count);
            rsp.status   <= ST_OK;
            state        <= IDLE;
          end else begin
            state <= INS_EV;
          end
        end
        INS_EV: begin
          if (ins_up) begin
            pos   <= pos >> 1;
            state <= INS_RD;
          end else begin
            done         <= 1'b1;
            rsp.data_out <= '0;
            rsp.is_empty <= (count == '0);
            rsp.entries  <= ENTRIES_W'(count);
            rsp.status   <= ST_OK;
            state        <= IDLE;
          end
        end
        EXT_RD0: begin
          state <= EXT_LD;
        end
        EXT_LD: begin
          top    <= qa;
          moving <= qb;
          pos    <= ONE_C;
          state  <= EXT_RD;
        end
        EXT_RD: begin
          if (!left_in) begin
            done         <= 1'b1;
            rsp.data_out <= DATA_IO_W'(top);
            rsp.is_empty <= (count == '0);
            rsp.entries  <= ENTRIES_W'(count);
            rsp.status   <= ST_OK;
            state        <= IDLE;
          end else begin
            state <= EXT_EV;
          end
        end
        EXT_EV: begin
          if (child_up) begin
            pos   <= pick_slot;
            state <= EXT_RD;
          end else begin
            done         <= 1'b1;
            rsp.data_out <= DATA_IO_W'(top);
            rsp.is_empty <= (count == '0);
            rsp.entries  <= ENTRIES_W'(count);
            rsp.status   <= ST_OK;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // result strobe only fires once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while sequencer busy");

  // never more live entries than slots
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  // every accepted command either reports at once or starts a walk
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command neither reported nor started");

  // a refused insert only happens on a full heap
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (count == CAP_C))
    else $error("insert refused below capacity");

  // the moving entry never walks past the live size
  a_pos_live: assert property (@(posedge clk) disable iff (rst)
    (state == EXT_EV) |-> (pos <= count))
    else $error("sift-down position beyond live entries");

endmodule

// ===== tb/sv/binary_heap_priority_queue_unit_tb.sv =====
// self-checking testbench for the binary heap priority queue unit
`timescale 1ns / 1ps

module binary_heap_priority_queue_unit_tb;
  import bhpq_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int DATA_WIDTH  = 32;
  // longest op: an insert climbing 6 levels or an extract descending 5
  localparam int DRAIN_WAIT  = 24;
  // no transfer of any kind for this many cycles means the unit hung
  localparam int STALL_LIMIT = 3000;
  localparam int PRINT_CAP   = 30;

  logic   clk = 1'b0;
  logic   rst;
  logic   start;
  cmd_t   cmd;
  logic   busy;
  logic   cfg_we;
  logic   cfg_wdata;
  logic   done;
  rsp_t   rsp;

  binary_heap_priority_queue_unit #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .rsp      (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow heap, one-based like the hardware
  logic [DATA_WIDTH-1:0] heap_shadow [1:CAPACITY];
  int                    heap_fill;
  logic                  min_first;

  cmd_t cmd_backlog [$];  // commands waiting to be offered
  rsp_t due_rsps [$];     // predicted responses, oldest first
  int   cmd_total;        // commands queued so far
  int   rsp_seen;         // response strobes observed
  int   send_idle_pct;    // chance of holding start low on a free cycle
  int   mismatches;
  int   stall_cycles;

  // strict priority compare under the current order
  function automatic bit outranks(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    return min_first ? (a < b) : (a > b);
  endfunction

  // apply one command to the shadow heap and return the response it yields
  function automatic rsp_t heap_apply(cmd_t c);
    rsp_t                  r;
    logic [DATA_WIDTH-1:0] moving;
    int                    pos;
    int                    up;
    int                    left;
    int                    pick;
    int                    size;
    r = '0;
    r.status = ST_OK;
    if (c.opcode == OP_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // sift up, stopping below a parent of equal priority
        pos = heap_fill + 1;
        while (pos > 1) begin
          up = pos / 2;
          if (!outranks(c.data_in, heap_shadow[up])) break;
          heap_shadow[pos] = heap_shadow[up];
          pos = up;
        end
        heap_shadow[pos] = c.data_in;
        heap_fill++;
      end
    end else if (heap_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.data_out = heap_shadow[1];
      moving = heap_shadow[heap_fill];
      size = heap_fill - 1;
      pos = 1;
      // sift down against the better child; left wins a tie between children
      while (1) begin
        left = pos * 2;
        if (left > size) break;
        pick = left;
        if (left < size && outranks(heap_shadow[left + 1], heap_shadow[left]))
          pick = left + 1;
        if (!outranks(heap_shadow[pick], moving)) break;
        heap_shadow[pos] = heap_shadow[pick];
        pos = pick;
      end
      if (size > 0) heap_shadow[pos] = moving;
      heap_fill = size;
    end
    r.is_empty = (heap_fill == 0);
    r.entries  = heap_fill[ENTRIES_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // command driver: hold start until the transfer, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // order register takes effect at the edge the write lands
      if (cfg_we) min_first = cfg_wdata;
      if (start && !busy) due_rsps.push_back(heap_apply(cmd));
      if (start && busy) begin
        // offer stays up until the unit takes it
      end else if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        cmd   <= cmd_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // response monitor: every done strobe is a transfer and is checked at once
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      rsp_seen++;
      if (due_rsps.size() == 0) begin
        report_mismatch("response with none pending", rsp.data_out, 32'd0);
      end else begin
        want = due_rsps.pop_front();
        if (rsp.data_out !== want.data_out)
          report_mismatch("data_out", rsp.data_out, want.data_out);
        if (rsp.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
        if (rsp.entries !== want.entries)
          report_mismatch("entries", 32'(rsp.entries), 32'(want.entries));
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
      end
    end
  end

  // hang detector: any transfer clears the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_cmd(opcode_t op, logic [DATA_WIDTH-1:0] value);
    cmd_t c;
    c.opcode  = op;
    c.data_in = value;
    cmd_backlog.push_back(c);
    cmd_total++;
  endtask

  // values biased toward ties and the ends of the range
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // a fill burst that runs into full, then a drain that runs into empty
  task automatic queue_fill_drain(int fill_len, int drain_len);
    repeat (fill_len)
      push_cmd($urandom_range(99) < 88 ? OP_INSERT : OP_EXTRACT, pick_value());
    repeat (drain_len)
      push_cmd($urandom_range(99) < 88 ? OP_EXTRACT : OP_INSERT, pick_value());
  endtask

  // wait until every queued command has reported, then let the unit settle
  task automatic wait_drained();
    while (rsp_seen < cmd_total) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register writes happen only with nothing outstanding
  task automatic write_order(logic value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int   phase_idle [6];
    logic phase_order [6];
    phase_idle    = '{0, 50, 0, 38, 50, 38};
    phase_order   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    heap_fill     = 0;
    min_first     = 1'b0;
    cmd_total     = 0;
    rsp_seen      = 0;
    send_idle_pct = 0;
    mismatches    = 0;
    stall_cycles  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty extract, extremes, equal parents and equal children
    write_order(1'b0);
    push_cmd(OP_EXTRACT, '1);
    push_cmd(OP_INSERT, '1);
    push_cmd(OP_INSERT, '0);
    push_cmd(OP_INSERT, 32'd5);
    push_cmd(OP_INSERT, 32'd5);
    push_cmd(OP_INSERT, 32'd5);
    push_cmd(OP_INSERT, 32'd7);
    push_cmd(OP_INSERT, 32'd5);
    push_cmd(OP_INSERT, 32'h8000_0000);
    push_cmd(OP_INSERT, 32'd1);
    repeat (10) push_cmd(OP_EXTRACT, 32'h5555_aaaa);
    wait_drained();

    // random: alternate order and sender idling; some phases keep old contents
    for (int p = 0; p < 6; p++) begin
      write_order(phase_order[p]);
      send_idle_pct = phase_idle[p];
      queue_fill_drain(90, 85);
      wait_drained();
    end

    if (due_rsps.size() != 0)
      report_mismatch("responses never seen", 32'(due_rsps.size()), 32'd0);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
